FILE: rtl/slm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Socket latency monitor package
// Table sizes, event codes, memory word layouts and hash functions.
// ----------------------------------------------------------------------------
package slm_pkg;

	localparam int SOCKET_ENTRIES = 1024;
	localparam int METRIC_ENTRIES = 4096;
	localparam int SW = $clog2(SOCKET_ENTRIES);
	localparam int MW = $clog2(METRIC_ENTRIES);
	localparam logic [SW:0] SOCK_N = (SW+1)'(SOCKET_ENTRIES);
	localparam logic [MW:0] METRIC_N = (MW+1)'(METRIC_ENTRIES);

	localparam logic [63:0] SLOW_RESET = 64'd1000000;
	localparam logic [63:0] REPORT_RESET = 64'd100000000;
	localparam logic [31:0] CNT_MAX = 32'hFFFF_FFFF;

	// Event codes.
	localparam logic [2:0] FUNC_CREATE  = 3'd0;
	localparam logic [2:0] FUNC_RECEIVE = 3'd1;
	localparam logic [2:0] FUNC_READ    = 3'd2;
	localparam logic [2:0] FUNC_WRITE   = 3'd3;
	localparam logic [2:0] FUNC_SEND    = 3'd4;
	localparam logic [2:0] FUNC_DESTROY = 3'd5;

	// Socket slot status codes.
	localparam logic [1:0] SLOT_EMPTY = 2'd0;
	localparam logic [1:0] SLOT_USED  = 2'd1;
	localparam logic [1:0] SLOT_TOMB  = 2'd2;

	// Register map.
	localparam logic REG_SLOW   = 1'b0;
	localparam logic REG_REPORT = 1'b1;

	typedef struct packed {
		logic [63:0] slow;
		logic [63:0] report;
	} cfg_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [63:0] key;
		logic [63:0] rcv;
		logic [63:0] wr;
	} sock_word_t;

	typedef struct packed {
		logic        valid;
		logic [63:0] owner;
		logic [13:0] tag;
		logic [31:0] count;
	} metric_word_t;

	// Home slot of a socket key, folded and wrapped into the table.
	function automatic logic [SW-1:0] sock_hash(logic [63:0] k);
		logic [63:0] x;
		logic [SW:0] t;
		x = k ^ (k >> 23) ^ (k >> 41);
		t = {1'b0, x[SW-1:0]};
		if (t >= SOCK_N) begin
			t = t - SOCK_N;
		end
		return t[SW-1:0];
	endfunction

	// Home slot of a counter key.
	function automatic logic [MW-1:0] metric_hash(logic [63:0] o, logic [13:0] g);
		logic [63:0] x;
		logic [MW:0] t;
		x = o ^ (o >> 29) ^ (o >> 47) ^ {50'd0, g} ^ {37'd0, g, 13'd0};
		t = {1'b0, x[MW-1:0]};
		if (t >= METRIC_N) begin
			t = t - METRIC_N;
		end
		return t[MW-1:0];
	endfunction

endpackage

FILE: rtl/slm_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One read or write per cycle, read data registered.
// ----------------------------------------------------------------------------
module slm_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = $clog2(DEPTH)
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    addr,
	input  logic [WIDTH-1:0] wdata,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		rdata <= mem[addr];
	end

endmodule

FILE: rtl/slm_regs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Socket latency monitor registers
// APB-style access to the slow and report thresholds.
// ----------------------------------------------------------------------------
module slm_regs (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          psel,
	input  logic          penable,
	input  logic          pwrite,
	input  logic [3:0]    paddr,
	input  logic [63:0]   pwdata,
	output logic [63:0]   prdata,
	output logic          pready,
	output slm_pkg::cfg_t cfg
);
	import slm_pkg::*;

	cfg_t cfg_q;
	logic wr_en;

	assign pready = 1'b1;
	assign wr_en = psel & penable & pwrite;
	assign cfg = cfg_q;

	// Register writes complete in the access phase.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.slow <= SLOW_RESET;
			cfg_q.report <= REPORT_RESET;
		end else if (wr_en) begin
			if (paddr[3] == REG_SLOW) begin
				cfg_q.slow <= pwdata;
			end else begin
				cfg_q.report <= pwdata;
			end
		end
	end

	// Read mux.
	assign prdata = (paddr[3] == REG_SLOW) ? cfg_q.slow : cfg_q.report;

endmodule

FILE: rtl/socket_latency_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Socket latency monitor
// Tracks socket stamps and counts slow read and send latencies.
// ----------------------------------------------------------------------------
// One socket event is a transaction on the in channel (in_valid, in_ready);
// a measured slow latency is a transaction on the out channel (out_valid,
// out_ready). The socket table and the counter table are single-port RAMs
// searched by linear probing from a hashed home slot, each probe a read
// state and a check state. An item is taken in idle, probes the socket table,
// writes it when it is updated, and for a counted latency passes S_LAT,
// probes the counter table, writes it in S_MWR unless the counter is dropped
// and ends in S_OUT. Ignored function codes are taken in idle; other events
// without a result finish after the socket lookup, the table write or S_LAT.
// After reset both tables are swept clear up to the size of the larger table,
// during which in_ready stays low; threshold writes are taken as ever.
// A finished result sits in the output register; the next event is
// accepted while it waits. A result ready while the previous one is still
// stalled holds the block until out_ready frees the register.
// Thresholds are written over the APB port at byte addresses 0 and 8.
// ----------------------------------------------------------------------------
module socket_latency_monitor (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	output logic [63:0] prdata,
	output logic        pready,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [2:0]  func,
	input  logic [63:0] socket_id,
	input  logic [63:0] now_ns,
	input  logic [31:0] netns,
	input  logic [31:0] pid,
	input  logic [11:0] cpu,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        action,
	output logic        over_report,
	output logic [63:0] latency_ns,
	output logic [63:0] sock_out,
	output logic [31:0] netns_out,
	output logic [31:0] pid_out,
	output logic [11:0] cpu_out,
	output logic [31:0] count,
	output logic        count_dropped
);
	import slm_pkg::*;

	localparam int CW = ((SW > MW) ? SW : MW) + 1;
	localparam logic [CW-1:0] CLR_LAST =
		CW'((SOCKET_ENTRIES > METRIC_ENTRIES) ? SOCKET_ENTRIES - 1 : METRIC_ENTRIES - 1);

	typedef enum logic [9:0] {
		S_CLEAR = 10'b00_0000_0001,
		S_IDLE  = 10'b00_0000_0010,
		S_SRD   = 10'b00_0000_0100,
		S_SCK   = 10'b00_0000_1000,
		S_SWR   = 10'b00_0001_0000,
		S_LAT   = 10'b00_0010_0000,
		S_MRD   = 10'b00_0100_0000,
		S_MCK   = 10'b00_1000_0000,
		S_MWR   = 10'b01_0000_0000,
		S_OUT   = 10'b10_0000_0000
	} state_t;

	state_t state_q;
	cfg_t cfg;

	// Event registers.
	logic [2:0]  func_q;
	logic [63:0] sock_q, now_q;
	logic [31:0] netns_q, pid_q;
	logic [11:0] cpu_q;

	// Probe and result registers.
	logic [CW-1:0] clr_q;
	logic [SW-1:0] sptr_q, free_idx_q, swr_addr_q;
	logic [SW:0]   scnt_q;
	logic          free_found_q;
	sock_word_t    swr_data_q;
	logic [MW-1:0] mptr_q;
	logic [MW:0]   mcnt_q;
	metric_word_t  mwr_data_q;
	logic [63:0]   lat_q;
	logic          act_q, high_q, drop_q;
	logic [31:0]   cnt_q;

	// Memory ports.
	logic          s_we, m_we;
	logic [SW-1:0] s_addr;
	logic [MW-1:0] m_addr;
	sock_word_t    s_wdata, s_rdata;
	metric_word_t  m_wdata, m_rdata;

	logic out_load;

	slm_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	slm_ram #(.WIDTH($bits(sock_word_t)), .DEPTH(SOCKET_ENTRIES)) u_sock_ram (
		.clk   (clk),
		.we    (s_we),
		.addr  (s_addr),
		.wdata (s_wdata),
		.rdata (s_rdata)
	);

	slm_ram #(.WIDTH($bits(metric_word_t)), .DEPTH(METRIC_ENTRIES)) u_metric_ram (
		.clk   (clk),
		.we    (m_we),
		.addr  (m_addr),
		.wdata (m_wdata),
		.rdata (m_rdata)
	);

	assign in_ready = (state_q == S_IDLE);

	// Memory address and write selection.
	always_comb begin
		s_we = 1'b0;
		m_we = 1'b0;
		s_addr = sptr_q;
		m_addr = mptr_q;
		s_wdata = swr_data_q;
		m_wdata = mwr_data_q;
		unique case (state_q)
			S_CLEAR: begin
				s_we = ({1'b0, clr_q} < {1'b0, CW'(SOCK_N)});
				m_we = ({1'b0, clr_q} < {1'b0, CW'(METRIC_N)});
				s_addr = clr_q[SW-1:0];
				m_addr = clr_q[MW-1:0];
				s_wdata = '0;
				m_wdata = '0;
			end
			S_SWR: begin
				s_we = 1'b1;
				s_addr = swr_addr_q;
			end
			S_MWR: begin
				m_we = 1'b1;
			end
			default: begin
			end
		endcase
	end

	assign out_load = (state_q == S_OUT) && (!out_valid || out_ready);

	// Sequencer state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_CLEAR;
			clr_q <= '0;
		end else begin
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == CLR_LAST) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid && func <= FUNC_DESTROY) begin
						state_q <= S_SRD;
					end
				end
				S_SRD: begin
					state_q <= S_SCK;
				end
				S_SCK: begin
					if (s_rdata.status == SLOT_USED && s_rdata.key == sock_q) begin
						if (func_q == FUNC_READ || func_q == FUNC_SEND) begin
							if (((func_q == FUNC_SEND) ? s_rdata.wr : s_rdata.rcv) == 64'd0) begin
								state_q <= S_IDLE;
							end else begin
								state_q <= S_LAT;
							end
						end else begin
							state_q <= S_SWR;
						end
					end else if (s_rdata.status == SLOT_EMPTY || scnt_q == SOCK_N - 1'b1) begin
						if (func_q == FUNC_CREATE &&
							(free_found_q || s_rdata.status != SLOT_USED)) begin
							state_q <= S_SWR;
						end else begin
							state_q <= S_IDLE;
						end
					end else begin
						state_q <= S_SRD;
					end
				end
				S_SWR: begin
					state_q <= S_IDLE;
				end
				S_LAT: begin
					state_q <= (lat_q > cfg.slow) ? S_MRD : S_IDLE;
				end
				S_MRD: begin
					state_q <= S_MCK;
				end
				S_MCK: begin
					if (m_rdata.valid && m_rdata.owner == mwr_data_q.owner &&
						m_rdata.tag == mwr_data_q.tag) begin
						state_q <= S_MWR;
					end else if (!m_rdata.valid) begin
						state_q <= S_MWR;
					end else if (mcnt_q == METRIC_N - 1'b1) begin
						state_q <= S_OUT;
					end else begin
						state_q <= S_MRD;
					end
				end
				S_MWR: begin
					state_q <= S_OUT;
				end
				S_OUT: begin
					if (out_load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_CLEAR;
				end
			endcase
		end
	end

	// Datapath registers for the event in flight.
	always_ff @(posedge clk) begin
		unique case (state_q)
			S_IDLE: begin
				func_q <= func;
				sock_q <= socket_id;
				now_q <= now_ns;
				netns_q <= netns;
				pid_q <= pid;
				cpu_q <= cpu;
				sptr_q <= sock_hash(socket_id);
				scnt_q <= '0;
				free_found_q <= 1'b0;
				act_q <= (func == FUNC_SEND);
			end
			S_SCK: begin
				if (s_rdata.status == SLOT_USED && s_rdata.key == sock_q) begin
					// Known socket: prepare the update or the measurement.
					swr_addr_q <= sptr_q;
					swr_data_q <= s_rdata;
					unique case (func_q)
						FUNC_CREATE: begin
							swr_data_q.rcv <= '0;
							swr_data_q.wr <= '0;
						end
						FUNC_RECEIVE: swr_data_q.rcv <= now_q;
						FUNC_WRITE: swr_data_q.wr <= now_q;
						FUNC_DESTROY: swr_data_q.status <= SLOT_TOMB;
						default: begin
						end
					endcase
					lat_q <= now_q - (act_q ? s_rdata.wr : s_rdata.rcv);
				end else begin
					// Track the first reusable slot on the probe path.
					if (!free_found_q && s_rdata.status != SLOT_USED) begin
						free_found_q <= 1'b1;
						free_idx_q <= sptr_q;
					end
					swr_addr_q <= free_found_q ? free_idx_q : sptr_q;
					swr_data_q.status <= SLOT_USED;
					swr_data_q.key <= sock_q;
					swr_data_q.rcv <= '0;
					swr_data_q.wr <= '0;
					sptr_q <= (sptr_q == SOCK_N[SW-1:0] - 1'b1) ? '0 : sptr_q + 1'b1;
					scnt_q <= scnt_q + 1'b1;
				end
			end
			S_LAT: begin
				high_q <= (lat_q > cfg.report);
				mwr_data_q.valid <= 1'b1;
				mwr_data_q.owner <= {netns_q, pid_q};
				mwr_data_q.tag <= {act_q, (lat_q > cfg.report), cpu_q};
				mptr_q <= metric_hash({netns_q, pid_q}, {act_q, (lat_q > cfg.report), cpu_q});
				mcnt_q <= '0;
			end
			S_MCK: begin
				// Saturating bump, insert at the first free slot, or drop.
				if (m_rdata.valid && m_rdata.owner == mwr_data_q.owner &&
					m_rdata.tag == mwr_data_q.tag) begin
					mwr_data_q.count <= (m_rdata.count == CNT_MAX) ? CNT_MAX
						: m_rdata.count + 1'b1;
					cnt_q <= (m_rdata.count == CNT_MAX) ? CNT_MAX : m_rdata.count + 1'b1;
					drop_q <= 1'b0;
				end else if (!m_rdata.valid) begin
					mwr_data_q.count <= 32'd1;
					cnt_q <= 32'd1;
					drop_q <= 1'b0;
				end else if (mcnt_q == METRIC_N - 1'b1) begin
					cnt_q <= '0;
					drop_q <= 1'b1;
				end else begin
					mptr_q <= (mptr_q == METRIC_N[MW-1:0] - 1'b1) ? '0 : mptr_q + 1'b1;
					mcnt_q <= mcnt_q + 1'b1;
				end
			end
			default: begin
			end
		endcase
	end

	// Output register valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (out_load) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	// Output payload.
	always_ff @(posedge clk) begin
		if (out_load) begin
			action <= act_q;
			over_report <= high_q;
			latency_ns <= lat_q;
			sock_out <= sock_q;
			netns_out <= netns_q;
			pid_out <= pid_q;
			cpu_out <= cpu_q;
			count <= cnt_q;
			count_dropped <= drop_q;
		end
	end

endmodule

FILE: test/slm_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Socket latency monitor checker
// Watches the event and result channels and the threshold writes, keeps its
// own socket and counter tables, and compares every result transaction with
// the oldest predicted one.
// ----------------------------------------------------------------------------
module slm_checker (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [3:0]  paddr,
	input  logic [63:0] pwdata,
	input  logic        pready,
	input  logic        in_valid,
	input  logic        in_ready,
	input  logic [2:0]  func,
	input  logic [63:0] socket_id,
	input  logic [63:0] now_ns,
	input  logic [31:0] netns,
	input  logic [31:0] pid,
	input  logic [11:0] cpu,
	input  logic        out_valid,
	input  logic        out_ready,
	input  logic        action,
	input  logic        over_report,
	input  logic [63:0] latency_ns,
	input  logic [63:0] sock_out,
	input  logic [31:0] netns_out,
	input  logic [31:0] pid_out,
	input  logic [11:0] cpu_out,
	input  logic [31:0] count,
	input  logic        count_dropped,
	output int          errors,
	output int          pending,
	output int          results_seen,
	output int          drops_seen
);
	import slm_pkg::*;

	typedef struct packed {
		logic        action;
		logic        high;
		logic [63:0] latency;
		logic [63:0] sock;
		logic [31:0] netns;
		logic [31:0] pid;
		logic [11:0] cpu;
		logic [31:0] count;
		logic        dropped;
	} latency_rec_t;

	// Predictor state.
	logic [63:0] slow_thr, report_thr;
	logic        s_valid [SOCKET_ENTRIES];
	logic [63:0] s_key   [SOCKET_ENTRIES];
	logic [63:0] s_rcv   [SOCKET_ENTRIES];
	logic [63:0] s_wr    [SOCKET_ENTRIES];
	logic        m_valid [METRIC_ENTRIES];
	logic [63:0] m_owner [METRIC_ENTRIES];
	logic [13:0] m_tag   [METRIC_ENTRIES];
	logic [31:0] m_count [METRIC_ENTRIES];
	latency_rec_t expected_q[$];

	assign pending = expected_q.size();

	function automatic int find_socket(logic [63:0] k);
		for (int i = 0; i < SOCKET_ENTRIES; i++)
			if (s_valid[i] && s_key[i] == k) return i;
		return -1;
	endfunction

	// Saturating counter bump; returns -1 when the table is full.
	function automatic longint bump_counter(logic [63:0] owner, logic [13:0] tag);
		int spare;
		spare = -1;
		for (int i = 0; i < METRIC_ENTRIES; i++) begin
			if (m_valid[i]) begin
				if (m_owner[i] == owner && m_tag[i] == tag) begin
					if (m_count[i] != CNT_MAX) m_count[i] = m_count[i] + 1;
					return m_count[i];
				end
			end else if (spare < 0) begin
				spare = i;
			end
		end
		if (spare < 0) return -1;
		m_valid[spare] = 1'b1;
		m_owner[spare] = owner;
		m_tag[spare] = tag;
		m_count[spare] = 1;
		return 1;
	endfunction

	// Apply one accepted event to the tables and queue any result.
	task automatic predict_event(logic [2:0] f, logic [63:0] sk, logic [63:0] t,
			logic [31:0] ns, logic [31:0] pd, logic [11:0] c);
		int slot;
		logic [63:0] stamp, lat;
		logic act, high;
		longint cnt;
		latency_rec_t r;
		slot = find_socket(sk);
		case (f)
			FUNC_CREATE: begin
				if (slot < 0) begin
					for (int i = 0; i < SOCKET_ENTRIES; i++)
						if (!s_valid[i]) begin
							slot = i;
							break;
						end
					if (slot >= 0) begin
						s_valid[slot] = 1'b1;
						s_key[slot] = sk;
					end
				end
				if (slot >= 0) begin
					s_rcv[slot] = '0;
					s_wr[slot] = '0;
				end
			end
			FUNC_RECEIVE: if (slot >= 0) s_rcv[slot] = t;
			FUNC_WRITE:   if (slot >= 0) s_wr[slot] = t;
			FUNC_DESTROY: if (slot >= 0) s_valid[slot] = 1'b0;
			FUNC_READ, FUNC_SEND: begin
				if (slot >= 0) begin
					act = (f == FUNC_SEND);
					stamp = act ? s_wr[slot] : s_rcv[slot];
					lat = t - stamp;
					if (stamp != 0 && lat > slow_thr) begin
						high = (lat > report_thr);
						cnt = bump_counter({ns, pd}, {act, high, c});
						r.action = act;
						r.high = high;
						r.latency = lat;
						r.sock = sk;
						r.netns = ns;
						r.pid = pd;
						r.cpu = c;
						r.count = (cnt < 0) ? 32'd0 : cnt[31:0];
						r.dropped = (cnt < 0);
						expected_q.push_back(r);
					end
				end
			end
			default: ;
		endcase
	endtask

	initial begin
		errors = 0;
		results_seen = 0;
		drops_seen = 0;
		slow_thr = SLOW_RESET;
		report_thr = REPORT_RESET;
		for (int i = 0; i < SOCKET_ENTRIES; i++) s_valid[i] = 1'b0;
		for (int i = 0; i < METRIC_ENTRIES; i++) m_valid[i] = 1'b0;
	end

	// Sample all channels at the rising edge.
	always @(posedge clk) begin
		latency_rec_t act_r, exp_r;
		if (arst_n) begin
			if (psel && penable && pwrite && pready) begin
				if (paddr[3] == REG_REPORT) report_thr <= pwdata;
				else slow_thr <= pwdata;
			end
			if (in_valid && in_ready)
				predict_event(func, socket_id, now_ns, netns, pid, cpu);
			if (out_valid && out_ready) begin
				act_r = '{action, over_report, latency_ns, sock_out, netns_out,
					pid_out, cpu_out, count, count_dropped};
				results_seen++;
				if (count_dropped) drops_seen++;
				if (expected_q.size() == 0) begin
					errors++;
					$display("%0t: unexpected result transaction, expected none, actual %h",
						$time, act_r);
				end else begin
					exp_r = expected_q.pop_front();
					if (act_r !== exp_r) begin
						errors++;
						$display("%0t: mismatch expected %h actual %h", $time, exp_r, act_r);
						$display("  action %b/%b high %b/%b lat %h/%h sock %h/%h",
							exp_r.action, act_r.action, exp_r.high, act_r.high,
							exp_r.latency, act_r.latency, exp_r.sock, act_r.sock);
						$display("  netns %h/%h pid %h/%h cpu %h/%h count %h/%h drop %b/%b",
							exp_r.netns, act_r.netns, exp_r.pid, act_r.pid, exp_r.cpu,
							act_r.cpu, exp_r.count, act_r.count, exp_r.dropped,
							act_r.dropped);
					end
				end
			end
		end
	end

endmodule

FILE: test/tb_socket_latency_monitor.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Socket latency monitor testbench
// Drives socket events and threshold writes under varying back-pressure;
// the checker predicts and compares every result transaction.
// ----------------------------------------------------------------------------
module tb_socket_latency_monitor;
	import slm_pkg::*;

	localparam int  CYCLE_LIMIT = 400000;
	localparam int  RANDOM_ITEMS = 1330;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [3:0]  paddr = '0;
	logic [63:0] pwdata = '0;
	logic [63:0] prdata;
	logic        pready;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [2:0]  func = '0;
	logic [63:0] socket_id = '0, now_ns = '0;
	logic [31:0] netns = '0, pid = '0;
	logic [11:0] cpu = '0;
	logic        out_valid, out_ready = 1'b0;
	logic        action, over_report, count_dropped;
	logic [63:0] latency_ns, sock_out;
	logic [31:0] netns_out, pid_out, count;
	logic [11:0] cpu_out;
	int          errors, pending, results_seen, drops_seen;
	int          cycles = 0;
	int          send_idle_pct = 0, recv_stall_pct = 0;
	int          events_sent = 0;
	logic [63:0] sock_pool [8];
	logic [63:0] clock_ns = 64'd1000;

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	socket_latency_monitor DUT (.*);

	slm_checker u_checker (.*);

	// Random receiver back-pressure.
	always @(posedge clk)
		out_ready <= ($urandom_range(99) >= recv_stall_pct);

	// Run limit.
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results pending", cycles, pending);
			$display("** socket_latency_monitor: FAILED **");
			$finish;
		end
	end

	task automatic write_reg(logic [3:0] addr, logic [63:0] value);
		@(posedge clk);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= addr;
		pwdata <= value;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
	endtask

	// One event transaction, with a random idle gap before it.
	task automatic send_event(logic [2:0] f, logic [63:0] sk, logic [63:0] t,
			logic [31:0] ns, logic [31:0] pd, logic [11:0] c);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		func <= f;
		socket_id <= sk;
		now_ns <= t;
		netns <= ns;
		pid <= pd;
		cpu <= c;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		events_sent++;
	endtask

	// Wait until no result is outstanding, then let the block settle.
	task automatic drain;
		in_valid <= 1'b0;
		while (pending != 0) @(posedge clk);
		repeat (40) @(posedge clk);
	endtask

	// Random event, mostly well-formed traffic on a small socket pool.
	task automatic random_event;
		logic [63:0] sk;
		logic [2:0] f;
		int pick;
		sk = sock_pool[$urandom_range(7)];
		if ($urandom_range(19) == 0) sk = {$urandom, $urandom};
		pick = $urandom_range(99);
		if (pick < 8) f = FUNC_CREATE;
		else if (pick < 28) f = FUNC_RECEIVE;
		else if (pick < 48) f = FUNC_READ;
		else if (pick < 66) f = FUNC_WRITE;
		else if (pick < 86) f = FUNC_SEND;
		else if (pick < 92) f = FUNC_DESTROY;
		else f = 3'($urandom_range(7));
		case ($urandom_range(9))
			0: clock_ns = {$urandom, $urandom};
			1: clock_ns = clock_ns + 64'd200000000 + $urandom_range(100000000);
			2, 3: clock_ns = clock_ns + $urandom_range(2000000);
			default: clock_ns = clock_ns + $urandom_range(60000000);
		endcase
		send_event(f, sk, clock_ns, $urandom_range(3) == 0 ? $urandom : $urandom_range(1),
			$urandom_range(3) == 0 ? $urandom : $urandom_range(2),
			$urandom_range(3) == 0 ? 12'($urandom) : 12'($urandom_range(3)));
	endtask

	task automatic random_phase(int n, int idle, int stall);
		send_idle_pct = idle;
		recv_stall_pct = stall;
		repeat (n) random_event();
	endtask

	initial begin
		for (int i = 0; i < 8; i++) sock_pool[i] = {$urandom, $urandom};
		sock_pool[0] = '0;
		sock_pool[1] = '1;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;

		// Directed: create, stamps, reads, sends, extremes and special cases.
		send_event(FUNC_READ, 64'd5, 64'd100, 0, 0, 0);          // unknown socket
		send_event(FUNC_CREATE, 64'd5, 64'd1, 0, 0, 0);
		send_event(FUNC_READ, 64'd5, 64'd9000000, 0, 0, 0);       // zero stamp
		send_event(FUNC_RECEIVE, 64'd5, 64'd1000, 0, 0, 0);
		send_event(FUNC_READ, 64'd5, 64'd1001000, 0, 0, 0);       // exactly at slow
		send_event(FUNC_READ, 64'd5, 64'd1001001, '1, '1, '1);    // just over slow
		send_event(FUNC_READ, 64'd5, 64'd1001001, '1, '1, '1);    // same key again
		send_event(FUNC_READ, 64'd5, 64'd100001001, '1, '1, '1);  // high bucket
		send_event(FUNC_WRITE, '1, 64'd7, 0, 0, 0);                // unknown socket
		send_event(FUNC_CREATE, '1, 64'd0, 0, 0, 0);
		send_event(FUNC_WRITE, '1, '1, 0, 0, 0);
		send_event(FUNC_SEND, '1, 64'd5000000, 32'h1234, 32'h5678, 12'h800); // wraps
		send_event(FUNC_RECEIVE, '1, 64'd0, 0, 0, 0);              // zero stamp written
		send_event(FUNC_READ, '1, '1, 0, 0, 0);
		send_event(FUNC_CREATE, '1, 64'd3, 0, 0, 0);               // clears stamps
		send_event(FUNC_SEND, '1, '1, 0, 0, 0);
		send_event(3'd6, 64'd5, 64'd1, 0, 0, 0);
		send_event(3'd7, 64'd5, 64'd1, 0, 0, 0);
		send_event(FUNC_DESTROY, 64'd5, 64'd0, 0, 0, 0);
		send_event(FUNC_DESTROY, 64'd5, 64'd0, 0, 0, 0);           // unknown
		send_event(FUNC_READ, 64'd5, '1, 0, 0, 0);                 // destroyed
		drain();

		// Thresholds at their extremes: every nonzero latency is counted and reported.
		write_reg(4'd0, 64'd0);
		write_reg(4'd8, 64'd0);
		random_phase(150, 0, 0);
		drain();
		// Nothing can exceed an all-ones slow threshold.
		write_reg(4'd0, '1);
		write_reg(4'd8, '1);
		random_phase(100, 50, 0);
		drain();
		write_reg(4'd0, 64'd500000);
		write_reg(4'd8, 64'd30000000);
		random_phase(350, 50, 0);
		random_phase(300, 0, 50);
		drain();
		write_reg(4'd0, SLOW_RESET);
		write_reg(4'd8, REPORT_RESET);
		random_phase(250, 10, 10);
		random_phase(180, 0, 0);
		drain();

		$display("Sent %0d socket events; %0d latency results checked, %0d dropped counters.",
			events_sent, results_seen, drops_seen);
		$display("Thresholds swept from zero to all ones under four back-pressure mixes.");
		if (errors == 0) begin
			$display("** socket_latency_monitor: PASSED **");
		end else begin
			$display("** socket_latency_monitor: FAILED **");
		end
		$finish;
	end

endmodule
